FILE: rtl/plas_pkg.sv
// Shared constants and word types for the polyline arc-length sampler.
package plas_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = ADDR_W + 1;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic        [1:0]  func;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] query_dist;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic        [31:0] path_length;
      logic        [8:0]  point_count;
      logic               status;
   } rsp_type;

endpackage

FILE: rtl/polyline_arc_length_sampler_top.sv
// Polyline arc-length sampler: point store, segment lengths, walk and interpolation.
//
//   channel | ports                    | handshake
//   --------+--------------------------+-------------------------------------------
//   request | start, busy, req_data    | word taken when start is high and busy low
//   response| rsp_valid, rsp_data      | one-cycle strobe, receiver cannot stall
//
// Clear, refused append, first append and empty-path sample answer straight
// from idle. A later append squares the deltas in three passes of the shared
// multiplier and then runs the bit-serial square root (32 steps), skipped when
// the squared length overflows. A sample at the path ends answers with the end
// point; else the one-segment-per-cycle length walk finds the segment, then the
// multiplier and the 32-step divider run once per axis.
// Reset clears the point count and the total; the stores are never cleared.
// The response strobe cannot be stalled; busy alone holds off new words.
module polyline_arc_length_sampler_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  plas_pkg::req_type req_data,
   output logic              rsp_valid,
   output plas_pkg::rsp_type rsp_data
);
   import plas_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_AP_RD, S_AP_DIF, S_AP_SQ, S_AP_RT0, S_AP_RT, S_AP_END,
      S_SM_SEL, S_SM_END, S_WK, S_PT_A, S_PT_B, S_PT_C, S_MUL, S_DIV, S_LERP
   } state_type;

   state_type state_ff;

   // point and segment-length stores, one write and one registered read each
   logic signed [31:0] mem_x [MAX_POINTS];
   logic signed [31:0] mem_y [MAX_POINTS];
   logic signed [31:0] mem_z [MAX_POINTS];
   logic        [31:0] mem_len [MAX_POINTS];

   logic signed [31:0] pt_qx_ff, pt_qy_ff, pt_qz_ff;
   logic        [31:0] seg_q_ff;
   logic [ADDR_W-1:0]  pt_ra, seg_ra, seg_wa;
   logic               pt_we, seg_we;

   logic [CNT_W-1:0]   count_ff;
   logic [31:0]        total_ff;
   logic signed [31:0] dist_ff;
   logic [31:0]        acc_ff, off_ff, len_ff;
   logic [ADDR_W-1:0]  idx_ff;
   logic signed [31:0] p0_ff [3];
   logic signed [31:0] p1_ff [3];
   logic signed [31:0] res_xyz_ff [3];
   logic [1:0]         coord_ff;
   logic [31:0]        dmag_ff [3];
   logic [65:0]        sum_ff;
   logic [63:0]        rt_n_ff, rt_res_ff, rt_bit_ff;
   logic [31:0]        rem_ff, lo_ff;
   logic [4:0]         step_ff;
   logic               neg_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic [ADDR_W-1:0]  last_idx;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        product;
   logic [32:0]        acc_sum, tot_sum, div_t, diff_c;
   logic [31:0]        acc_new, tot_new, amag_c;
   logic [63:0]        rt_try;
   logic signed [32:0] pd [3];

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign last_idx = ADDR_W'(count_ff - CNT_W'(1));
   assign pt_we    = accept && (req_data.func == FUNC_APPEND) &&
                     (count_ff < CNT_W'(MAX_POINTS));
   assign seg_we   = (state_ff == S_AP_END);
   // the segment that ends at the new point starts at the previous one
   assign seg_wa   = last_idx;

   // read address selection
   always_comb begin
      pt_ra  = idx_ff;
      seg_ra = idx_ff + ADDR_W'(1);
      unique case (state_ff)
         S_AP_RD:  pt_ra = last_idx;
         S_SM_SEL: begin
            pt_ra  = (dist_ff < 0) ? '0 : last_idx;
            seg_ra = '0;
         end
         S_PT_B:   pt_ra = idx_ff + ADDR_W'(1);
         default:  pt_ra = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         mem_x[count_ff[ADDR_W-1:0]] <= req_data.px;
         mem_y[count_ff[ADDR_W-1:0]] <= req_data.py;
         mem_z[count_ff[ADDR_W-1:0]] <= req_data.pz;
      end
      if (seg_we) begin
         mem_len[seg_wa] <= rt_res_ff[31:0];
      end
      pt_qx_ff <= mem_x[pt_ra];
      pt_qy_ff <= mem_y[pt_ra];
      pt_qz_ff <= mem_z[pt_ra];
      seg_q_ff <= mem_len[seg_ra];
   end

   // shared multiplier: squares for append, |d| * offset for interpolation
   always_comb begin
      pd[0]  = {p1_ff[0][31], p1_ff[0]} - {p0_ff[0][31], p0_ff[0]};
      pd[1]  = {p1_ff[1][31], p1_ff[1]} - {p0_ff[1][31], p0_ff[1]};
      pd[2]  = {p1_ff[2][31], p1_ff[2]} - {p0_ff[2][31], p0_ff[2]};
      diff_c = pd[0];
      case (coord_ff)
         2'd1:    diff_c = pd[1];
         2'd2:    diff_c = pd[2];
         default: diff_c = pd[0];
      endcase
      amag_c = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
      if (state_ff == S_AP_SQ) begin
         // square passes run on coord 1..3, one axis behind
         mul_a = dmag_ff[coord_ff - 2'd1];
         mul_b = dmag_ff[coord_ff - 2'd1];
      end else begin
         mul_a = amag_c;
         mul_b = off_ff;
      end
      product = 64'(mul_a) * 64'(mul_b);
      acc_sum = {1'b0, acc_ff} + {1'b0, seg_q_ff};
      acc_new = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      tot_sum = {1'b0, total_ff} + {1'b0, rt_res_ff[31:0]};
      tot_new = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
      div_t   = {rem_ff, lo_ff[31]};
      rt_try  = rt_res_ff + rt_bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  // outputs stay zero unless a sample fills them later
                  rsp_ff.out_x <= '0;
                  rsp_ff.out_y <= '0;
                  rsp_ff.out_z <= '0;
                  case (req_data.func)
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                        total_ff <= '0;
                        rsp_ff.path_length <= '0;
                        rsp_ff.point_count <= '0;
                        rsp_ff.status      <= STATUS_OK;
                        rsp_valid_ff <= 1'b1;
                     end
                     FUNC_APPEND: begin
                        p1_ff[0] <= req_data.px;
                        p1_ff[1] <= req_data.py;
                        p1_ff[2] <= req_data.pz;
                        if (count_ff >= CNT_W'(MAX_POINTS)) begin
                           rsp_ff.status      <= STATUS_FULL;
                           rsp_ff.path_length <= total_ff;
                           rsp_ff.point_count <= count_ff;
                           rsp_valid_ff  <= 1'b1;
                        end else if (count_ff == '0) begin
                           count_ff <= CNT_W'(1);
                           total_ff <= '0;
                           rsp_ff.status      <= STATUS_OK;
                           rsp_ff.path_length <= '0;
                           rsp_ff.point_count <= CNT_W'(1);
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff.status <= STATUS_OK;
                           state_ff <= S_AP_RD;
                        end
                     end
                     FUNC_SAMPLE: begin
                        dist_ff <= req_data.query_dist;
                        rsp_ff.status      <= STATUS_OK;
                        rsp_ff.path_length <= total_ff;
                        rsp_ff.point_count <= count_ff;
                        if (count_ff == '0) rsp_valid_ff <= 1'b1;
                        else state_ff <= S_SM_SEL;
                     end
                     default: begin
                        rsp_ff.status      <= STATUS_OK;
                        rsp_ff.path_length <= total_ff;
                        rsp_ff.point_count <= count_ff;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_AP_RD: state_ff <= S_AP_DIF;
            S_AP_DIF: begin
               // hold the previous point as p0; the delta magnitudes are taken in S_AP_SQ
               p0_ff[0] <= pt_qx_ff;
               p0_ff[1] <= pt_qy_ff;
               p0_ff[2] <= pt_qz_ff;
               coord_ff <= 2'd0;
               sum_ff   <= '0;
               state_ff <= S_AP_SQ;
            end
            S_AP_SQ: begin
               if (coord_ff == 2'd0) begin
                  dmag_ff[0] <= pd[0][32] ? 32'(-pd[0]) : pd[0][31:0];
                  dmag_ff[1] <= pd[1][32] ? 32'(-pd[1]) : pd[1][31:0];
                  dmag_ff[2] <= pd[2][32] ? 32'(-pd[2]) : pd[2][31:0];
                  coord_ff   <= 2'd1;
               end else begin
                  sum_ff <= sum_ff + 66'(product);
                  if (coord_ff == 2'd3) state_ff <= S_AP_RT0;
                  coord_ff <= coord_ff + 2'd1;
               end
            end
            S_AP_RT0: begin
               if (sum_ff[65:64] != 2'b00) begin
                  rt_res_ff <= 64'h0000_0000_FFFF_FFFF;
                  state_ff  <= S_AP_END;
               end else begin
                  rt_n_ff   <= sum_ff[63:0];
                  rt_res_ff <= '0;
                  rt_bit_ff <= 64'h4000_0000_0000_0000;
                  state_ff  <= S_AP_RT;
               end
            end
            S_AP_RT: begin
               if (rt_n_ff >= rt_try) begin
                  rt_n_ff   <= rt_n_ff - rt_try;
                  rt_res_ff <= (rt_res_ff >> 1) + rt_bit_ff;
               end else begin
                  rt_res_ff <= rt_res_ff >> 1;
               end
               rt_bit_ff <= rt_bit_ff >> 2;
               if (rt_bit_ff[0]) state_ff <= S_AP_END;
            end
            S_AP_END: begin
               total_ff <= tot_new;
               count_ff <= count_ff + CNT_W'(1);
               rsp_ff.path_length <= tot_new;
               rsp_ff.point_count <= count_ff + CNT_W'(1);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_SM_SEL: begin
               idx_ff <= '0;
               acc_ff <= '0;
               if (dist_ff < 0 || 32'(dist_ff) >= total_ff) state_ff <= S_SM_END;
               else state_ff <= S_WK;
            end
            S_SM_END: begin
               rsp_ff.out_x <= pt_qx_ff;
               rsp_ff.out_y <= pt_qy_ff;
               rsp_ff.out_z <= pt_qz_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_WK: begin
               // one segment a cycle; the next length is already being read
               if (32'(dist_ff) < acc_new) begin
                  off_ff   <= 32'(dist_ff) - acc_ff;
                  len_ff   <= seg_q_ff;
                  state_ff <= S_PT_A;
               end else if (idx_ff == last_idx - ADDR_W'(1)) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  acc_ff <= acc_new;
                  idx_ff <= idx_ff + ADDR_W'(1);
               end
            end
            S_PT_A: state_ff <= S_PT_B;
            S_PT_B: begin
               p0_ff[0] <= pt_qx_ff;
               p0_ff[1] <= pt_qy_ff;
               p0_ff[2] <= pt_qz_ff;
               state_ff <= S_PT_C;
            end
            S_PT_C: begin
               p1_ff[0] <= pt_qx_ff;
               p1_ff[1] <= pt_qy_ff;
               p1_ff[2] <= pt_qz_ff;
               coord_ff <= 2'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               // high half is below the length, so 32 steps give the quotient
               rem_ff   <= product[63:32];
               lo_ff    <= product[31:0];
               neg_ff   <= diff_c[32];
               step_ff  <= 5'd31;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_t >= {1'b0, len_ff}) begin
                  rem_ff <= 32'(div_t - {1'b0, len_ff});
                  lo_ff  <= {lo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= div_t[31:0];
                  lo_ff  <= {lo_ff[30:0], 1'b0};
               end
               step_ff <= step_ff - 5'd1;
               if (step_ff == 5'd0) state_ff <= S_LERP;
            end
            S_LERP: begin
               res_xyz_ff[coord_ff] <= neg_ff ? p0_ff[coord_ff] - $signed(lo_ff)
                                              : p0_ff[coord_ff] + $signed(lo_ff);
               if (coord_ff == 2'd2) begin
                  rsp_ff.out_x <= res_xyz_ff[0];
                  rsp_ff.out_y <= res_xyz_ff[1];
                  rsp_ff.out_z <= neg_ff ? p0_ff[2] - $signed(lo_ff)
                                         : p0_ff[2] + $signed(lo_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  coord_ff <= coord_ff + 2'd1;
                  state_ff <= S_MUL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS)) else $error("point count beyond store");
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid) else $error("accepted word neither worked nor answered");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.point_count == CNT_W'(MAX_POINTS))
      else $error("full flag with room left");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still working");

endmodule
